### rtl/vt4_pkg.sv
package vt4_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned PROD_W        = 2 * DATA_W;
  localparam int unsigned PAIR_W        = PROD_W + 1;
  localparam int unsigned SUM_W         = PROD_W + 2;
  localparam int unsigned N_DIM         = 4;
  localparam int unsigned N_COEF        = N_DIM * N_DIM;
  localparam int unsigned IDX_W         = $clog2(N_COEF);
  localparam int unsigned OP_W          = 2;
  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_VEC4  = 2'd1,
    OP_POINT = 2'd2
  } op_e;

  typedef logic signed [DATA_W-1:0] word_t;

  // per-stage load enables of the datapath
  typedef struct packed {
    logic en_b;
    logic en_c;
    logic en_d;
  } pipe_en_t;

endpackage

### rtl/vt4_if.sv
interface vt4_req_if import vt4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [IDX_W-1:0]  coef_index;
  word_t             coef_value;
  word_t             in_x;
  word_t             in_y;
  word_t             in_z;
  word_t             in_w;

  modport source (
    output valid, opcode, coef_index, coef_value, in_x, in_y, in_z, in_w,
    input  ready
  );
  modport sink (
    input  valid, opcode, coef_index, coef_value, in_x, in_y, in_z, in_w,
    output ready
  );
endinterface

interface vt4_rsp_if import vt4_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t out_x;
  word_t out_y;
  word_t out_z;
  word_t out_w;
  logic  saturated;

  modport source (
    output valid, out_x, out_y, out_z, out_w, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w, saturated,
    output ready
  );
endinterface

### rtl/vt4_coef_store.sv
module vt4_coef_store import vt4_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [IDX_W-1:0] idx_i,
  input  word_t            data_i,
  output word_t            coef_o [N_COEF]
);

  word_t mem_q [N_COEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_COEF; i++) begin
        mem_q[i] <= '0;
      end
    end else if (we_i) begin
      mem_q[idx_i] <= data_i;
    end
  end

  assign coef_o = mem_q;

endmodule

### rtl/vt4_row.sv
module vt4_row import vt4_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  pipe_en_t en_i,
  input  word_t    coef_i [N_DIM],
  input  word_t    vec_i  [N_DIM],
  output word_t    res_o,
  output logic     sat_o
);

  localparam word_t WordMax = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(DATA_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_d [N_DIM];
  logic signed [PROD_W-1:0] prod_q [N_DIM];
  logic signed [PAIR_W-1:0] pair_d [2];
  logic signed [PAIR_W-1:0] pair_q [2];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;
  logic                     in_range;
  word_t                    res_d;
  word_t                    res_q;
  logic                     sat_d;
  logic                     sat_q;

  always_comb begin
    for (int c = 0; c < N_DIM; c++) begin
      prod_d[c] = coef_i[c] * vec_i[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_b) begin
      prod_q <= prod_d;
    end
  end

  assign pair_d[0] = PAIR_W'(prod_q[0]) + PAIR_W'(prod_q[1]);
  assign pair_d[1] = PAIR_W'(prod_q[2]) + PAIR_W'(prod_q[3]);

  always_ff @(posedge clk_i) begin
    if (en_i.en_c) begin
      pair_q <= pair_d;
    end
  end

  // arithmetic shift floors toward minus infinity
  assign sum      = SUM_W'(pair_q[0]) + SUM_W'(pair_q[1]);
  assign shifted  = sum >>> FRAC_BITS;
  assign in_range = (&shifted[SUM_W-1:DATA_W-1]) || !(|shifted[SUM_W-1:DATA_W-1]);

  always_comb begin
    if (in_range) begin
      res_d = shifted[DATA_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      res_d = WordMin;
    end else begin
      res_d = WordMax;
    end
    sat_d = !in_range;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_d) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

### rtl/vertex_transform_4x4.sv
// 4x4 matrix times 4-vector, signed fixed point with FRAC_BITS fraction bits.
// requests arrive on req_i (valid/ready). opcode OP_LOAD writes coef_value
// into the matrix at coef_index (column*4+row) and gives no result; OP_VEC4
// and OP_POINT transform (in_x, in_y, in_z, in_w) and give one result on
// rsp_o. point mode takes w as 1.0, reports out_w as 0 and leaves w out of
// the saturated flag. opcode 3 is dropped without effect.
// a result passes through the input register, 16 parallel 32x32
// multipliers, pair adders and a final add with shift and saturation
// into the output register.
// throughput: one request per cycle while req_i.ready is high, loads and
// transforms freely mixed; a load takes effect for every transform accepted after it.
// when rsp_o.ready is low the result holds and the pipeline keeps filling
// its empty stages; req_i.ready drops only once every stage is full.
// reset clears all valid bits and sets every coefficient to zero.
module vertex_transform_4x4 import vt4_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  vt4_req_if.sink   req_i,
  vt4_rsp_if.source rsp_o
);

  localparam word_t OneFx = word_t'(1 << FRAC_BITS);

  pipe_en_t         pipe_en;
  logic             en_a;
  logic             v_a_q, v_b_q, v_c_q, v_d_q;
  logic             pt_b_q, pt_c_q, pt_d_q;
  logic [OP_W-1:0]  op_a_q;
  logic [IDX_W-1:0] idx_a_q;
  word_t            val_a_q;
  word_t            vec_a_q [N_DIM];
  word_t            vec_a_d [N_DIM];
  logic             load_a;
  logic             xform_a;
  logic             point_a;
  logic             coef_we;
  word_t            coef [N_COEF];
  word_t            row_coef [N_DIM][N_DIM];
  word_t            res [N_DIM];
  logic [N_DIM-1:0] sat;

  // a stage takes new content when empty or when its content moves on
  assign pipe_en.en_d = !v_d_q || rsp_o.ready;
  assign pipe_en.en_c = !v_c_q || pipe_en.en_d;
  assign pipe_en.en_b = !v_b_q || pipe_en.en_c;
  assign en_a         = !v_a_q || pipe_en.en_b;
  assign req_i.ready  = en_a;

  assign load_a  = (op_a_q == OP_LOAD);
  assign point_a = (op_a_q == OP_POINT);
  assign xform_a = (op_a_q == OP_VEC4) || point_a;

  always_comb begin
    vec_a_d[0] = req_i.in_x;
    vec_a_d[1] = req_i.in_y;
    vec_a_d[2] = req_i.in_z;
    vec_a_d[3] = (req_i.opcode == OP_POINT) ? OneFx : req_i.in_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
    end else begin
      if (en_a) begin
        v_a_q <= req_i.valid;
      end
      if (pipe_en.en_b) begin
        v_b_q <= v_a_q && xform_a;
      end
      if (pipe_en.en_c) begin
        v_c_q <= v_b_q;
      end
      if (pipe_en.en_d) begin
        v_d_q <= v_c_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      op_a_q  <= req_i.opcode;
      idx_a_q <= req_i.coef_index;
      val_a_q <= req_i.coef_value;
      vec_a_q <= vec_a_d;
    end
    if (pipe_en.en_b) begin
      pt_b_q <= point_a;
    end
    if (pipe_en.en_c) begin
      pt_c_q <= pt_b_q;
    end
    if (pipe_en.en_d) begin
      pt_d_q <= pt_c_q;
    end
  end

  // loads write as they leave the input stage, keeping request order
  assign coef_we = v_a_q && load_a && pipe_en.en_b;

  vt4_coef_store u_coef_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (coef_we),
    .idx_i  (idx_a_q),
    .data_i (val_a_q),
    .coef_o (coef)
  );

  for (genvar r = 0; r < N_DIM; r++) begin : g_row
    for (genvar c = 0; c < N_DIM; c++) begin : g_col
      assign row_coef[r][c] = coef[c*N_DIM + r];
    end

    vt4_row #(
      .FRAC_BITS (FRAC_BITS)
    ) u_row (
      .clk_i  (clk_i),
      .en_i   (pipe_en),
      .coef_i (row_coef[r]),
      .vec_i  (vec_a_q),
      .res_o  (res[r]),
      .sat_o  (sat[r])
    );
  end

  assign rsp_o.valid     = v_d_q;
  assign rsp_o.out_x     = res[0];
  assign rsp_o.out_y     = res[1];
  assign rsp_o.out_z     = res[2];
  assign rsp_o.out_w     = pt_d_q ? '0 : res[3];
  assign rsp_o.saturated = sat[0] || sat[1] || sat[2] || (sat[3] && !pt_d_q);

`ifndef SYNTH
  localparam word_t ChkMax = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t ChkMin = {1'b1, {(DATA_W-1){1'b0}}};

  a_point_w_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && pt_d_q |-> rsp_o.out_w == '0)
    else $error("point result with nonzero w");

  a_sat_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.saturated |->
      rsp_o.out_x == ChkMax || rsp_o.out_x == ChkMin ||
      rsp_o.out_y == ChkMax || rsp_o.out_y == ChkMin ||
      rsp_o.out_z == ChkMax || rsp_o.out_z == ChkMin ||
      rsp_o.out_w == ChkMax || rsp_o.out_w == ChkMin)
    else $error("saturated flag without a clipped component");

  a_stage_b_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_b_q && !pipe_en.en_c |=> v_b_q && $stable(pt_b_q))
    else $error("stalled product stage lost its item");
`endif

endmodule
